FILE: rtl/audio_frame_cobs_crc_decoder_assert.svh
// Assertion macros shared by the audio frame COBS/CRC decoder modules.
// Standalone header; included by the modules that carry assertions.
`ifndef AUDIO_FRAME_COBS_CRC_DECODER_ASSERT_SVH
`define AUDIO_FRAME_COBS_CRC_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define AFCD_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("afcd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AFCD_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("afcd assertion failed");

`endif

FILE: rtl/afcd_pkg.sv
// Types and constants of the audio frame COBS/CRC decoder.
// No dependencies; used by the RTL modules, checker and testbench.
`default_nettype none

package afcd_pkg;

  typedef logic [0:0] cfg_index_t;

  localparam cfg_index_t CFG_PACKET_TYPE = 1'b0;
  localparam cfg_index_t CFG_MAX_PAYLOAD = 1'b1;

  localparam logic [7:0] PACKET_TYPE_RESET = 8'h01;
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'hFF;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  CODE_FULL_GROUP = 8'hFF;

  localparam int HEADER_BYTES = 9;
  localparam int MIN_RAW_BYTES = 11;
  // Width that holds any raw byte count plus header length arithmetic.
  localparam int CNT_CMP_W = 10;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_MAX  = 3'd1;
  localparam logic [2:0] ST_COBS      = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_CRC       = 3'd4;
  localparam logic [2:0] ST_TYPE      = 3'd5;
  localparam logic [2:0] ST_LENGTH    = 3'd6;
  localparam logic [2:0] ST_TOO_LONG  = 3'd7;

  localparam int RESULT_DEPTH = 4;
  localparam int RESULT_PTR_W = 2;
  localparam int RESULT_CNT_W = 3;

  typedef struct packed {
    logic [7:0] enc_byte;
    logic       frame_end;
  } enc_item_t;

  typedef struct packed {
    logic               is_status;
    logic [7:0]         payload_byte;
    logic [2:0]         status;
    logic [15:0]        sequence_res;
    logic [15:0]        sample_total;
    logic signed [15:0] predictor;
    logic signed [7:0]  step_index;
    logic [7:0]         payload_len;
    logic               last;
  } result_t;

  typedef struct packed {
    logic pay;
    logic stat;
  } push_t;

endpackage

`default_nettype wire

FILE: rtl/afcd_stream_if.sv
// Valid/ready stream channel used for the encoded input and the results.
// The payload type is set per instance; no other dependencies.
`default_nettype none

interface afcd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/audio_frame_cobs_crc_decoder.sv
// Top level of the audio frame COBS/CRC decoder.
// Depends on afcd_pkg, afcd_stream_if, afcd_decoder and afcd_result_fifo.
// One encoded byte is taken per cycle: COBS group counting, the byte-wide
// CRC-16 update and header capture settle in the same cycle, and each byte
// is accepted while the four-entry result queue holds at most two results.
// A byte yields at most one payload byte, and a byte with frame_end also
// yields the frame status, so a frame-closing byte can put two results in
// the queue, which drains one result per cycle while res.ready is high.
// Payload bytes come out as they decode, ahead of the status; keep them
// only when the status is ok. There is no clearing pass after reset.
`default_nettype none

module audio_frame_cobs_crc_decoder #(
  parameter int RAW_BUFFER_BYTES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire afcd_pkg::cfg_index_t cfg_index,
  input  wire logic [7:0]           cfg_data,
  afcd_stream_if.sink               enc,
  afcd_stream_if.source             res
);

  afcd_pkg::push_t   push;
  afcd_pkg::result_t pay_res;
  afcd_pkg::result_t stat_res;
  afcd_pkg::result_t out_data;
  logic              space;
  logic              out_valid;
  logic              accept;

  assign enc.ready   = space;
  assign accept      = enc.valid && space;
  assign res.valid   = out_valid;
  assign res.payload = out_data;

  afcd_decoder #(
    .RAW_BUFFER_BYTES(RAW_BUFFER_BYTES)
  ) u_decoder (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (enc.payload),
    .push     (push),
    .pay_res  (pay_res),
    .stat_res (stat_res)
  );

  afcd_result_fifo u_result_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pay_res  (pay_res),
    .stat_res (stat_res),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(res.ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/afcd_decoder.sv
// COBS decode, CRC-16 check, header capture and end-of-frame status.
// Depends on afcd_pkg and the assertion macro header.
`default_nettype none
`include "audio_frame_cobs_crc_decoder_assert.svh"

module afcd_decoder #(
  parameter int RAW_BUFFER_BYTES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire afcd_pkg::cfg_index_t cfg_index,
  input  wire logic [7:0]          cfg_data,
  input  wire logic                accept,
  input  wire afcd_pkg::enc_item_t item,
  output afcd_pkg::push_t          push,
  output afcd_pkg::result_t        pay_res,
  output afcd_pkg::result_t        stat_res
);

  localparam int CW = $clog2(RAW_BUFFER_BYTES + 1);
  localparam int CmpW = afcd_pkg::CNT_CMP_W;

  logic [7:0]    packet_type_code;
  logic [7:0]    max_payload;
  logic [7:0]    group_left, group_left_next;
  logic [7:0]    group_code, group_code_next;
  logic          zero_owed, zero_owed_next;
  logic [CW-1:0] raw_count, raw_count_next;
  logic [15:0]   crc_acc, crc_acc_next;
  logic [7:0]    holdback0, holdback0_next;
  logic [7:0]    holdback1, holdback1_next;
  logic [7:0]    header_store [afcd_pkg::HEADER_BYTES];
  logic [7:0]    header_store_next [afcd_pkg::HEADER_BYTES];
  logic          decode_fault, decode_fault_next;

  logic          take;
  logic [7:0]    take_byte;
  logic          emit;
  logic [2:0]    status_code;
  logic [CmpW-1:0] raw_ext;
  logic [CmpW-1:0] expected_len;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ afcd_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  always_comb begin
    group_left_next   = group_left;
    group_code_next   = group_code;
    zero_owed_next    = zero_owed;
    raw_count_next    = raw_count;
    crc_acc_next      = crc_acc;
    holdback0_next    = holdback0;
    holdback1_next    = holdback1;
    header_store_next = header_store;
    decode_fault_next = decode_fault;
    take              = 1'b0;
    take_byte         = item.enc_byte;
    emit              = 1'b0;

    if (!decode_fault) begin
      if (group_left == 8'h00) begin
        take_byte = 8'h00;
        if (item.enc_byte == 8'h00) begin
          decode_fault_next = 1'b1;
        end else if (zero_owed) begin
          zero_owed_next = 1'b0;
          take           = 1'b1;
        end
      end else begin
        take = 1'b1;
      end
    end

    if (take) begin
      if (raw_count >= CW'(RAW_BUFFER_BYTES)) begin
        decode_fault_next = 1'b1;
      end else begin
        if (raw_count >= CW'(2)) begin
          crc_acc_next = crc16_byte(crc_acc, holdback0);
          for (int i = 0; i < afcd_pkg::HEADER_BYTES; i++) begin
            if (raw_count == CW'(i + 2)) begin
              header_store_next[i] = holdback0;
            end
          end
          emit           = raw_count > CW'(afcd_pkg::HEADER_BYTES + 1);
          holdback0_next = holdback1;
          holdback1_next = take_byte;
        end else if (raw_count[0]) begin
          holdback1_next = take_byte;
        end else begin
          holdback0_next = take_byte;
        end
        raw_count_next = raw_count + CW'(1);
      end
    end

    if (!decode_fault && !decode_fault_next) begin
      if (group_left == 8'h00) begin
        group_code_next = item.enc_byte;
        group_left_next = item.enc_byte - 8'h01;
        if (item.enc_byte == 8'h01) begin
          zero_owed_next = 1'b1;
        end
      end else begin
        group_left_next = group_left - 8'h01;
        if (group_left == 8'h01) begin
          zero_owed_next = (group_code != afcd_pkg::CODE_FULL_GROUP);
        end
      end
    end
  end

  assign raw_ext      = CmpW'(raw_count_next);
  assign expected_len = CmpW'(afcd_pkg::MIN_RAW_BYTES) + CmpW'(header_store_next[5]);

  always_comb begin
    priority if (max_payload == 8'h00) begin
      status_code = afcd_pkg::ST_ZERO_MAX;
    end else if (decode_fault_next || group_left_next != 8'h00) begin
      status_code = afcd_pkg::ST_COBS;
    end else if (raw_ext < CmpW'(afcd_pkg::MIN_RAW_BYTES)) begin
      status_code = afcd_pkg::ST_SHORT;
    end else if ({holdback1_next, holdback0_next} != crc_acc_next) begin
      status_code = afcd_pkg::ST_CRC;
    end else if (header_store_next[0] != packet_type_code) begin
      status_code = afcd_pkg::ST_TYPE;
    end else if (expected_len != raw_ext) begin
      status_code = afcd_pkg::ST_LENGTH;
    end else if (header_store_next[5] > max_payload) begin
      status_code = afcd_pkg::ST_TOO_LONG;
    end else begin
      status_code = afcd_pkg::ST_OK;
    end
  end

  always_comb begin
    pay_res              = '0;
    pay_res.payload_byte = holdback0;

    stat_res              = '0;
    stat_res.is_status    = 1'b1;
    stat_res.status       = status_code;
    stat_res.sequence_res = {header_store_next[2], header_store_next[1]};
    stat_res.sample_total = {header_store_next[4], header_store_next[3]};
    stat_res.predictor    = {header_store_next[7], header_store_next[6]};
    stat_res.step_index   = header_store_next[8];
    stat_res.payload_len  = header_store_next[5];
    stat_res.last         = 1'b1;

    push.pay  = accept && emit;
    push.stat = accept && item.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_type_code <= afcd_pkg::PACKET_TYPE_RESET;
      max_payload      <= afcd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afcd_pkg::CFG_PACKET_TYPE: packet_type_code <= cfg_data;
        afcd_pkg::CFG_MAX_PAYLOAD: max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && item.frame_end)) begin
      group_left   <= '0;
      group_code   <= '0;
      zero_owed    <= 1'b0;
      raw_count    <= '0;
      crc_acc      <= afcd_pkg::CRC_INIT;
      holdback0    <= '0;
      holdback1    <= '0;
      decode_fault <= 1'b0;
      for (int i = 0; i < afcd_pkg::HEADER_BYTES; i++) begin
        header_store[i] <= '0;
      end
    end else if (accept) begin
      group_left   <= group_left_next;
      group_code   <= group_code_next;
      zero_owed    <= zero_owed_next;
      raw_count    <= raw_count_next;
      crc_acc      <= crc_acc_next;
      holdback0    <= holdback0_next;
      holdback1    <= holdback1_next;
      decode_fault <= decode_fault_next;
      header_store <= header_store_next;
    end
  end

  `AFCD_ASSERT_NEXT(a_frame_end_clears, clk, rst, accept && item.frame_end,
                    raw_count == '0 && !decode_fault && group_left == 8'h00)
  `AFCD_ASSERT_IMP(a_raw_count_bound, clk, rst, 1'b1, raw_count <= CW'(RAW_BUFFER_BYTES))
  `AFCD_ASSERT_NEXT(a_fault_sticky, clk, rst, decode_fault && !(accept && item.frame_end),
                    decode_fault)
  `AFCD_ASSERT_IMP(a_payload_after_header, clk, rst, push.pay,
                   raw_count > CW'(afcd_pkg::HEADER_BYTES + 1) && !decode_fault)

endmodule

`default_nettype wire

FILE: rtl/afcd_result_fifo.sv
// Small result queue: takes up to two results per cycle, one out when read.
// Depends on afcd_pkg and the assertion macro header.
`default_nettype none
`include "audio_frame_cobs_crc_decoder_assert.svh"

module afcd_result_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire afcd_pkg::push_t   push,
  input  wire afcd_pkg::result_t pay_res,
  input  wire afcd_pkg::result_t stat_res,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output afcd_pkg::result_t      out_data
);

  localparam int PW = afcd_pkg::RESULT_PTR_W;
  localparam int NW = afcd_pkg::RESULT_CNT_W;

  afcd_pkg::result_t mem [afcd_pkg::RESULT_DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] stat_ptr;
  logic [NW-1:0] count;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign space     = count <= NW'(afcd_pkg::RESULT_DEPTH - 2);
  assign stat_ptr  = push.pay ? wr_ptr + PW'(1) : wr_ptr;
  assign wr_ptr_next = wr_ptr + PW'(push.pay) + PW'(push.stat);

  always_ff @(posedge clk) begin
    if (push.pay) begin
      mem[wr_ptr] <= pay_res;
    end
    if (push.stat) begin
      mem[stat_ptr] <= stat_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + NW'(push.pay) + NW'(push.stat) - NW'(pop);
    end
  end

  `AFCD_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= NW'(afcd_pkg::RESULT_DEPTH))
  `AFCD_ASSERT_IMP(a_push_has_room, clk, rst, push.pay || push.stat,
                   count <= NW'(afcd_pkg::RESULT_DEPTH - 2))
  `AFCD_ASSERT_NEXT(a_idle_holds, clk, rst, !pop && !push.pay && !push.stat,
                    count == $past(count) && rd_ptr == $past(rd_ptr))

endmodule

`default_nettype wire

FILE: verif/audio_frame_cobs_crc_decoder_chk.sv
`timescale 1ns / 100ps
// Result checker for the audio frame COBS/CRC decoder: decodes every accepted
// encoded byte on its own, queues the payload bytes and frame status it expects
// and compares them with the results. Depends on afcd_pkg.

module audio_frame_cobs_crc_decoder_chk
  import afcd_pkg::*;
#(
  parameter int RAW_BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        enc_valid,
  input  logic        enc_ready,
  input  enc_item_t   enc_item,
  input  logic        res_valid,
  input  logic        res_ready,
  input  result_t     res_item,
  output int          errors,
  output int          pending,
  output int          frames_seen,
  output int          payload_seen,
  output logic [7:0]  status_seen
);

  logic [7:0]  type_code;
  logic [7:0]  max_len;
  logic [7:0]  group_left;
  logic [7:0]  group_code;
  logic        zero_owed;
  int unsigned raw_count;
  logic [15:0] crc_acc;
  logic [7:0]  held_old;
  logic [7:0]  held_new;
  logic [7:0]  header [HEADER_BYTES];
  logic        fault;

  result_t     expected_results [$];
  int          err_cnt = 0;
  int          frame_cnt = 0;
  int          payload_cnt = 0;
  logic [7:0]  codes_hit = '0;

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic clear_frame();
    group_left = '0;
    group_code = '0;
    zero_owed  = 1'b0;
    raw_count  = 0;
    crc_acc    = CRC_INIT;
    held_old   = '0;
    held_new   = '0;
    foreach (header[i]) header[i] = '0;
    fault      = 1'b0;
  endtask

  // The two newest raw bytes stay back as the received CRC; older ones feed
  // the CRC and land in the header or leave as payload.
  task automatic take_raw(input logic [7:0] b);
    result_t r;
    if (raw_count >= RAW_BUFFER_BYTES) begin
      fault = 1'b1;
      return;
    end
    if (raw_count >= 2) begin
      crc_acc = crc16_step(crc_acc, held_old);
      if (raw_count - 2 < HEADER_BYTES) begin
        header[raw_count - 2] = held_old;
      end else begin
        r = '0;
        r.payload_byte = held_old;
        expected_results.push_back(r);
      end
      held_old = held_new;
      held_new = b;
    end else if (raw_count == 0) begin
      held_old = b;
    end else begin
      held_new = b;
    end
    raw_count++;
  endtask

  task automatic decode_request(input enc_item_t it);
    result_t    r;
    logic [2:0] st;
    if (!fault) begin
      if (group_left == 0) begin
        if (it.enc_byte == 8'h00) begin
          fault = 1'b1;
        end else begin
          if (zero_owed) begin
            zero_owed = 1'b0;
            take_raw(8'h00);
          end
          if (!fault) begin
            group_code = it.enc_byte;
            group_left = it.enc_byte - 8'd1;
            if (group_left == 0) zero_owed = (it.enc_byte != CODE_FULL_GROUP);
          end
        end
      end else begin
        take_raw(it.enc_byte);
        if (!fault) begin
          group_left = group_left - 8'd1;
          if (group_left == 0) zero_owed = (group_code != CODE_FULL_GROUP);
        end
      end
    end
    if (it.frame_end) begin
      if (max_len == 0) st = ST_ZERO_MAX;
      else if (fault || group_left != 0) st = ST_COBS;
      else if (raw_count < MIN_RAW_BYTES) st = ST_SHORT;
      else if ({held_new, held_old} != crc_acc) st = ST_CRC;
      else if (header[0] != type_code) st = ST_TYPE;
      else if (MIN_RAW_BYTES + int'(header[5]) != int'(raw_count)) st = ST_LENGTH;
      else if (header[5] > max_len) st = ST_TOO_LONG;
      else st = ST_OK;
      r = '0;
      r.is_status    = 1'b1;
      r.status       = st;
      r.sequence_res = {header[2], header[1]};
      r.sample_total = {header[4], header[3]};
      r.predictor    = {header[7], header[6]};
      r.step_index   = header[8];
      r.payload_len  = header[5];
      r.last         = 1'b1;
      expected_results.push_back(r);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      type_code = PACKET_TYPE_RESET;
      max_len   = MAX_PAYLOAD_RESET;
      clear_frame();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PACKET_TYPE) type_code = cfg_data;
        else if (cfg_index == CFG_MAX_PAYLOAD) max_len = cfg_data;
      end
      if (enc_valid && enc_ready) decode_request(enc_item);
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: is_status %0b payload 0x%0h status %0d",
                 res_item.is_status, res_item.payload_byte, res_item.status);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("is_status", want.is_status, res_item.is_status);
          check_field("payload_byte", want.payload_byte, res_item.payload_byte);
          check_field("status", want.status, res_item.status);
          check_field("sequence_res", want.sequence_res, res_item.sequence_res);
          check_field("sample_total", want.sample_total, res_item.sample_total);
          check_field("predictor", want.predictor, res_item.predictor);
          check_field("step_index", want.step_index, res_item.step_index);
          check_field("payload_len", want.payload_len, res_item.payload_len);
          check_field("last", want.last, res_item.last);
          if (want.is_status) begin
            frame_cnt++;
            codes_hit[want.status] = 1'b1;
          end else begin
            payload_cnt++;
          end
        end
      end
    end
    errors       <= err_cnt;
    pending      <= expected_results.size();
    frames_seen  <= frame_cnt;
    payload_seen <= payload_cnt;
    status_seen  <= codes_hit;
  end

endmodule

FILE: verif/audio_frame_cobs_crc_decoder_tb.sv
`timescale 1ns / 100ps
// Testbench top of the audio frame COBS/CRC decoder: builds COBS-encoded audio
// frames, good and broken, under several register settings and gives the verdict.
// Depends on afcd_pkg, afcd_stream_if, the decoder and its result checker.

module audio_frame_cobs_crc_decoder_tb;
  import afcd_pkg::*;

  localparam int RAW_BUFFER_BYTES = 256;
  localparam int DRAIN_CYCLES     = 16;
  localparam int HOLD_OFF_AT      = 100;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int PHASE_BYTES      = 30;

  typedef logic [7:0] byte_q_t [$];

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  logic [7:0] cfg_data;

  afcd_stream_if #(.payload_t(enc_item_t)) enc_ch ();
  afcd_stream_if #(.payload_t(result_t))   res_ch ();

  int         errors;
  int         pending;
  int         frames_seen;
  int         payload_seen;
  logic [7:0] status_seen;

  int         bytes_sent = 0;
  int         send_burst = 0;
  int         recv_burst = 0;
  logic [7:0] type_code;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  audio_frame_cobs_crc_decoder #(.RAW_BUFFER_BYTES(RAW_BUFFER_BYTES)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .enc       (enc_ch),
    .res       (res_ch)
  );

  audio_frame_cobs_crc_decoder_chk #(.RAW_BUFFER_BYTES(RAW_BUFFER_BYTES)) chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .enc_valid    (enc_ch.valid),
    .enc_ready    (enc_ch.ready),
    .enc_item     (enc_ch.payload),
    .res_valid    (res_ch.valid),
    .res_ready    (res_ch.ready),
    .res_item     (res_ch.payload),
    .errors       (errors),
    .pending      (pending),
    .frames_seen  (frames_seen),
    .payload_seen (payload_seen),
    .status_seen  (status_seen)
  );

  // Mostly random waits, with occasional stretches of back-to-back requests.
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic byte_q_t with_crc(byte_q_t raw);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (raw[i]) begin
      crc = crc ^ {raw[i], 8'h00};
      for (int k = 0; k < 8; k++) crc = crc[15] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
    raw.push_back(crc[7:0]);
    raw.push_back(crc[15:8]);
    return raw;
  endfunction

  function automatic byte_q_t audio_frame(logic [7:0] ptype, logic [7:0] len_field,
                                          int n_pay, int zero_pct);
    byte_q_t     raw;
    logic [15:0] seq;
    logic [15:0] cnt;
    logic [15:0] pred;
    logic [7:0]  step_idx;
    seq      = 16'($urandom);
    cnt      = 16'($urandom);
    pred     = 16'($urandom);
    step_idx = 8'($urandom);
    raw = {ptype, seq[7:0], seq[15:8], cnt[7:0], cnt[15:8], len_field,
           pred[7:0], pred[15:8], step_idx};
    repeat (n_pay) begin
      raw.push_back(($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255)));
    end
    return with_crc(raw);
  endfunction

  function automatic byte_q_t cobs_pack(byte_q_t raw);
    byte_q_t    enc;
    int         code_at;
    logic [7:0] code;
    enc.push_back(8'h00);
    code_at = 0;
    code    = 8'd1;
    foreach (raw[i]) begin
      if (raw[i] == 8'h00) begin
        enc[code_at] = code;
        code_at = enc.size();
        enc.push_back(8'h00);
        code = 8'd1;
      end else begin
        enc.push_back(raw[i]);
        code++;
        if (code == CODE_FULL_GROUP) begin
          enc[code_at] = code;
          code_at = enc.size();
          enc.push_back(8'h00);
          code = 8'd1;
        end
      end
    end
    enc[code_at] = code;
    return enc;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic frame_last);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      enc_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    enc_ch.valid   <= 1'b1;
    enc_ch.payload <= '{enc_byte: b, frame_end: frame_last};
    do @(posedge clk); while (!enc_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t enc);
    foreach (enc[i]) send_byte(enc[i], i == enc.size() - 1);
  endtask

  // Waits until every expected result is back and the decoder has gone quiet.
  task automatic settle();
    enc_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_index_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PACKET_TYPE) type_code = val;
  endtask

  task automatic send_random_frame();
    int      pick;
    int      n_pay;
    int      zero_pct;
    int      pos;
    byte_q_t raw;
    byte_q_t enc;
    pick     = $urandom_range(0, 99);
    n_pay    = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 250) : $urandom_range(0, 24);
    zero_pct = $urandom_range(0, 2) * 25;
    if (pick < 60) begin
      raw = audio_frame(type_code, 8'(n_pay), n_pay, zero_pct);
    end else if (pick < 67) begin
      raw = audio_frame(type_code ^ 8'($urandom_range(1, 255)), 8'(n_pay), n_pay, zero_pct);
    end else if (pick < 74) begin
      raw = audio_frame(type_code, 8'(n_pay + $urandom_range(1, 255)), n_pay, zero_pct);
    end else if (pick < 81) begin
      raw = audio_frame(type_code, 8'(n_pay), n_pay, zero_pct);
      pos = raw.size() - 1 - $urandom_range(0, 1);
      raw[pos] = raw[pos] ^ (8'h01 << $urandom_range(0, 7));
    end else if (pick < 86) begin
      repeat ($urandom_range(0, 10)) raw.push_back(8'($urandom));
    end else begin
      raw = audio_frame(type_code, 8'(n_pay), n_pay, zero_pct);
    end
    enc = cobs_pack(raw);
    if (pick >= 86 && pick < 91) begin
      enc[$urandom_range(0, enc.size() - 1)] = 8'h00;
    end else if (pick >= 91 && pick < 96) begin
      repeat ($urandom_range(1, 3)) if (enc.size() > 1) void'(enc.pop_back());
    end else if (pick >= 96) begin
      enc.delete();
      repeat ($urandom_range(1, 20)) enc.push_back(8'($urandom));
    end
    send_frame(enc);
  endtask

  // Receiver: random stalls, plus one long hold-off that backs the decoder up.
  initial begin
    int stall;
    int taken;
    res_ch.ready = 1'b0;
    taken = 0;
    @(posedge clk);
    forever begin
      stall = (taken == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : draw_wait(recv_burst);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      taken++;
    end
  end

  initial begin
    byte_q_t frame;
    int      target;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_PACKET_TYPE;
    cfg_data       = '0;
    enc_ch.valid   = 1'b0;
    enc_ch.payload = '0;
    type_code      = PACKET_TYPE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Good empty-payload frame whose header holds zeros and field extremes.
    frame = {PACKET_TYPE_RESET, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h80};
    send_frame(cobs_pack(with_crc(frame)));
    // Zero code byte, too few raw bytes, truncated full group, empty frame,
    // and bytes after a zero code byte that must be ignored.
    frame = {8'h00};
    send_frame(frame);
    frame = {8'h03, 8'h11, 8'h22};
    send_frame(frame);
    frame = {CODE_FULL_GROUP, 8'hFF};
    send_frame(frame);
    frame = {8'h01};
    send_frame(frame);
    frame = {8'h02, 8'h55, 8'h00, 8'h33};
    send_frame(frame);

    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: begin
          write_cfg(CFG_PACKET_TYPE, 8'h00);
          write_cfg(CFG_MAX_PAYLOAD, 8'hFF);
        end
        1: begin
          write_cfg(CFG_PACKET_TYPE, 8'hFF);
          write_cfg(CFG_MAX_PAYLOAD, 8'h00);
        end
        2: begin
          write_cfg(CFG_PACKET_TYPE, 8'($urandom));
          write_cfg(CFG_MAX_PAYLOAD, 8'hFF);
        end
        3: begin
          write_cfg(CFG_PACKET_TYPE, 8'($urandom));
          write_cfg(CFG_MAX_PAYLOAD, 8'($urandom_range(1, 30)));
        end
        default: begin
          write_cfg(CFG_PACKET_TYPE, PACKET_TYPE_RESET);
          write_cfg(CFG_MAX_PAYLOAD, 8'h01);
        end
      endcase
      if (phase == 2) begin
        // A frame that just fills the raw buffer and one that overflows it.
        send_frame(cobs_pack(audio_frame(type_code, 8'd245, 245, 0)));
        send_frame(cobs_pack(audio_frame(type_code, 8'd250, 250, 0)));
      end
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_random_frame();
    end
    settle();

    $display("Sent %0d encoded bytes; checked %0d frame statuses and %0d payload bytes.",
             bytes_sent, frames_seen, payload_seen);
    $display("Status codes reported (one bit per code, code 0 rightmost): %b", status_seen);
    if (errors == 0) begin
      $display("audio_frame_cobs_crc_decoder_tb: done, clean");
    end else begin
      $display("audio_frame_cobs_crc_decoder_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still expected.", pending);
    $display("audio_frame_cobs_crc_decoder_tb: done, errors");
    $finish;
  end

endmodule
